// ----- hw/rtl/ieas_pkg.sv -----
// Package for the I2C EEPROM access sequencer.
// Holds the phase encoding, the event and action codes and the error codes.
// No dependencies.
package ieas_pkg;

    typedef enum logic [15:0] {
        PH_IDLE     = 16'h0001,
        PH_CTRL     = 16'h0002,
        PH_AHI      = 16'h0004,
        PH_ALO      = 16'h0008,
        PH_WWAIT    = 16'h0010,
        PH_WSENT    = 16'h0020,
        PH_WSTOP    = 16'h0040,
        PH_PBYTE    = 16'h0080,
        PH_PSTOP    = 16'h0100,
        PH_RSTOP    = 16'h0200,
        PH_RCTRL    = 16'h0400,
        PH_RBODY    = 16'h0800,
        PH_RLAST    = 16'h1000,
        PH_RFINAL   = 16'h2000,
        PH_RSTOPEND = 16'h4000,
        PH_DRAIN    = 16'h8000
    } phase_t;

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_DATA  = 3'd2;
    localparam logic [2:0] KIND_BDONE = 3'd3;
    localparam logic [2:0] KIND_SDONE = 3'd4;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_SEND  = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;
    localparam logic [2:0] ACT_LREAD = 3'd5;
    localparam logic [2:0] ACT_REQ   = 3'd6;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_CTRL       = 4'd1;
    localparam logic [3:0] ERR_AHI        = 4'd2;
    localparam logic [3:0] ERR_ALO        = 4'd3;
    localparam logic [3:0] ERR_WDATA      = 4'd4;
    localparam logic [3:0] ERR_READ_BASE  = 4'd4;
    localparam logic [3:0] ERR_RCTRL      = 4'd8;
    localparam logic [3:0] ERR_RBODY      = 4'd9;
    localparam logic [3:0] ERR_RPRELAST   = 4'd10;
    localparam logic [3:0] ERR_RLAST2     = 4'd11;
    localparam logic [3:0] ERR_RLAST      = 4'd12;

    localparam logic [1:0] CFG_DEVSEL = 2'd0;
    localparam logic [1:0] CFG_PAGE   = 2'd1;
    localparam logic [1:0] CFG_WIDE   = 2'd2;

    localparam logic [7:0] CTRL_BASE = 8'hA0;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;      // Latch address and count from the begin beat.
        logic chunk_go;  // Start computing the page chunk.
        logic chunk_dec; // One data byte acknowledged.
        logic advance;   // Chunk polled good: move address and count on.
        logic rd_dec;    // One body byte read.
    } dp_cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic chunk_busy;
        logic chunk_last;
        logic rem_zero;
        logic rem_zero_adv;
    } dp_stat_t;

endpackage

// ----- hw/rtl/i2c_eeprom_access_sequencer.sv -----
// Top level of the I2C EEPROM access sequencer.
// Holds the configuration registers and joins ieas_controller and ieas_datapath.
// Depends on ieas_pkg.
//
// Usage: the input channel (in_valid/in_stall) carries one event per beat:
// begin write, begin read, write data byte, byte done or stop done, with
// the fields that event needs. The output channel (out_valid/out_stall)
// carries at most one result beat per input beat: the next bus action for
// the byte-level master, a delivered read byte, or the end of the operation.
// Except as below, a result is registered and appears in the cycle after the
// input beat that caused it. The address-low byte-done of a write waits for
// the 16-step shift-and-subtract remainder in the datapath and then a step
// that forms the chunk before its result is registered. The input is stalled
// during that computation and while a result waits under out_stall; the
// result register holds it.
// Reset clears the phase to idle and the registers to device_select 0,
// page_size 16, wide_address 1. Configuration is written through cfg_write,
// cfg_index and cfg_data; the user must write it only while the block is idle, which the block does not enforce.
module i2c_eeprom_access_sequencer
    import ieas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] mem_address,
    input  logic [15:0] byte_count,
    input  logic [7:0]  data_byte,
    input  logic        ack_received,
    input  logic        bus_error,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  tx_byte,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        finished,
    output logic        success,
    output logic [3:0]  error_code
);

    logic [2:0]  devsel_reg;
    logic [7:0]  page_reg;
    logic        wide_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [15:0] cur_address;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            devsel_reg <= 3'd0;
            page_reg   <= 8'd16;
            wide_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEVSEL: devsel_reg <= cfg_data[2:0];
                CFG_PAGE:   page_reg   <= cfg_data;
                CFG_WIDE:   wide_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    ieas_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_address  (mem_address),
        .in_count    (byte_count),
        .page_size   (page_reg),
        .stat        (stat),
        .cur_address (cur_address)
    );

    ieas_controller u_controller (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .data_byte     (data_byte),
        .ack_received  (ack_received),
        .bus_error     (bus_error),
        .rx_byte       (rx_byte),
        .device_select (devsel_reg),
        .wide_address  (wide_reg),
        .byte_count    (byte_count),
        .cur_address   (cur_address),
        .stat          (stat),
        .cmd           (cmd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .tx_byte       (tx_byte),
        .read_valid    (read_valid),
        .read_data     (read_data),
        .finished      (finished),
        .success       (success),
        .error_code    (error_code)
    );

endmodule

// ----- hw/rtl/ieas_datapath.sv -----
// Datapath of the I2C EEPROM access sequencer: address, counts and the chunk unit.
// The chunk size uses a 16-step shift-and-subtract remainder, one address bit a cycle.
// Depends on ieas_pkg.
module ieas_datapath
    import ieas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [15:0] in_address,
    input  logic [15:0] in_count,
    input  logic [7:0]  page_size,
    output dp_stat_t    stat,
    output logic [15:0] cur_address
);

    logic [15:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [8:0]  csize_reg, csize_next;
    logic [8:0]  cleft_reg, cleft_next;
    logic [8:0]  mod_reg, mod_next;
    logic [15:0] sh_reg, sh_next;
    logic [4:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [8:0]  ps;
    logic [9:0]  ps10;
    logic [9:0]  trial;
    logic [9:0]  trial_sub;
    logic [8:0]  chunk;
    logic [15:0] rem_adv;

    assign ps        = (page_size == 8'd0) ? 9'd256 : {1'b0, page_size};
    assign ps10      = {1'b0, ps};
    assign trial     = {mod_reg, sh_reg[15]};
    assign trial_sub = trial - ps10;
    assign chunk     = ps - mod_reg;
    assign rem_adv   = rem_reg - {7'd0, csize_reg};

    always_comb
    begin
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        csize_next = csize_reg;
        cleft_next = cleft_reg;
        mod_next   = mod_reg;
        sh_next    = sh_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        if (cmd.load)
        begin
            addr_next  = in_address;
            rem_next   = in_count;
            csize_next = 9'd0;
            cleft_next = 9'd0;
        end
        if (cmd.chunk_go)
        begin
            mod_next  = 9'd0;
            sh_next   = addr_reg;
            step_next = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg != 5'd0)
            begin
                sh_next   = {sh_reg[14:0], 1'b0};
                step_next = step_reg - 5'd1;
                if (trial >= ps10)
                begin
                    mod_next = trial_sub[8:0];
                end
                else
                begin
                    mod_next = trial[8:0];
                end
            end
            else
            begin
                busy_next = 1'b0;
                if (rem_reg < {7'd0, chunk})
                begin
                    csize_next = rem_reg[8:0];
                    cleft_next = rem_reg[8:0];
                end
                else
                begin
                    csize_next = chunk;
                    cleft_next = chunk;
                end
            end
        end
        if (cmd.chunk_dec && cleft_reg != 9'd0)
        begin
            cleft_next = cleft_reg - 9'd1;
        end
        if (cmd.advance)
        begin
            rem_next  = rem_adv;
            addr_next = addr_reg + {7'd0, csize_reg};
        end
        if (cmd.rd_dec)
        begin
            rem_next = rem_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= 16'd0;
            rem_reg   <= 16'd0;
            csize_reg <= 9'd0;
            cleft_reg <= 9'd0;
            mod_reg   <= 9'd0;
            sh_reg    <= 16'd0;
            step_reg  <= 5'd0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            csize_reg <= csize_next;
            cleft_reg <= cleft_next;
            mod_reg   <= mod_next;
            sh_reg    <= sh_next;
            step_reg  <= step_next;
            busy_reg  <= busy_next;
        end
    end

    assign stat.chunk_busy   = busy_reg;
    assign stat.chunk_last   = (cleft_reg <= 9'd1);
    assign stat.rem_zero     = (rem_reg == 16'd0);
    assign stat.rem_zero_adv = (rem_adv == 16'd0);
    assign cur_address       = addr_reg;

endmodule

// ----- hw/rtl/ieas_controller.sv -----
// Controller of the I2C EEPROM access sequencer: phase machine and result register.
// Depends on ieas_pkg and drives the datapath through dp_cmd_t.
module ieas_controller
    import ieas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        ack_received,
    input  logic        bus_error,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  device_select,
    input  logic        wide_address,
    input  logic [15:0] byte_count,
    input  logic [15:0] cur_address,
    input  dp_stat_t    stat,
    output dp_cmd_t     cmd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  tx_byte,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        finished,
    output logic        success,
    output logic [3:0]  error_code
);

    phase_t      phase_reg, phase_next;
    logic        rd_reg, rd_next;
    logic        ov_reg, ov_next;
    logic        calc_reg, calc_next;
    logic [2:0]  act_reg, act_next;
    logic [7:0]  tx_reg, tx_next;
    logic        rv_reg, rv_next;
    logic [7:0]  rdat_reg, rdat_next;
    logic        fin_reg, fin_next;
    logic        ok_reg, ok_next;
    logic [3:0]  err_reg, err_next;
    logic        acc, emit, bdone, sdone;
    logic [3:0]  base;
    logic [7:0]  ctrl_w, ctrl_r;

    assign in_stall = (ov_reg && out_stall) || calc_reg;
    assign acc      = in_valid && !in_stall;
    assign bdone    = (kind == KIND_BDONE);
    assign sdone    = (kind == KIND_SDONE);
    assign base     = rd_reg ? ERR_READ_BASE : ERR_NONE;
    assign ctrl_w   = CTRL_BASE | {4'd0, device_select, 1'b0};
    assign ctrl_r   = ctrl_w | 8'h01;

    always_comb
    begin
        phase_next = phase_reg;
        rd_next    = rd_reg;
        calc_next  = calc_reg;
        cmd        = '0;
        emit       = 1'b0;
        act_next   = ACT_NONE;
        tx_next    = 8'd0;
        rv_next    = 1'b0;
        rdat_next  = 8'd0;
        fin_next   = 1'b0;
        ok_next    = 1'b0;
        err_next   = ERR_NONE;
        if (calc_reg && !stat.chunk_busy)
        begin
            calc_next  = 1'b0;
            emit       = 1'b1;
            act_next   = ACT_REQ;
            phase_next = PH_WWAIT;
        end
        else if (acc)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (kind == KIND_WRITE || kind == KIND_READ)
                    begin
                        cmd.load = 1'b1;
                        rd_next  = kind[0];
                        emit     = 1'b1;
                        if (kind == KIND_WRITE && byte_count == 16'd0)
                        begin
                            fin_next = 1'b1;
                            ok_next  = 1'b1;
                        end
                        else
                        begin
                            act_next   = ACT_START;
                            tx_next    = ctrl_w;
                            phase_next = PH_CTRL;
                        end
                    end
                end
                PH_CTRL:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1;
                        if (bus_error || (!rd_reg && !ack_received))
                        begin
                            act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = base + ERR_CTRL; phase_next = PH_DRAIN;
                        end
                        else if (wide_address)
                        begin
                            act_next = ACT_SEND; tx_next = cur_address[15:8];
                            phase_next = PH_AHI;
                        end
                        else
                        begin
                            act_next = ACT_SEND; tx_next = cur_address[7:0];
                            phase_next = PH_ALO;
                        end
                    end
                end
                PH_AHI:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1;
                        if (bus_error)
                        begin
                            act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = base + ERR_AHI; phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            act_next = ACT_SEND; tx_next = cur_address[7:0];
                            phase_next = PH_ALO;
                        end
                    end
                end
                PH_ALO:
                begin
                    if (bdone)
                    begin
                        if (bus_error)
                        begin
                            emit = 1'b1; act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = base + ERR_ALO; phase_next = PH_DRAIN;
                        end
                        else if (rd_reg)
                        begin
                            emit = 1'b1; act_next = ACT_STOP; phase_next = PH_RSTOP;
                        end
                        else
                        begin
                            cmd.chunk_go = 1'b1;
                            calc_next    = 1'b1;
                        end
                    end
                end
                PH_WWAIT:
                begin
                    if (kind == KIND_DATA)
                    begin
                        emit = 1'b1; act_next = ACT_SEND; tx_next = data_byte;
                        phase_next = PH_WSENT;
                    end
                end
                PH_WSENT:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1;
                        if (bus_error || !ack_received)
                        begin
                            act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = ERR_WDATA; phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            cmd.chunk_dec = 1'b1;
                            if (!stat.chunk_last)
                            begin
                                act_next = ACT_REQ; phase_next = PH_WWAIT;
                            end
                            else
                            begin
                                act_next = ACT_STOP; phase_next = PH_WSTOP;
                            end
                        end
                    end
                end
                PH_WSTOP:
                begin
                    if (sdone)
                    begin
                        emit = 1'b1; act_next = ACT_START; tx_next = ctrl_w;
                        phase_next = PH_PBYTE;
                    end
                end
                PH_PBYTE:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1; act_next = ACT_STOP; phase_next = PH_PSTOP;
                    end
                end
                PH_PSTOP:
                begin
                    if (sdone)
                    begin
                        emit = 1'b1;
                        if (!ack_received)
                        begin
                            act_next = ACT_START; tx_next = ctrl_w;
                            phase_next = PH_PBYTE;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            if (stat.rem_zero_adv)
                            begin
                                fin_next = 1'b1; ok_next = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                act_next = ACT_START; tx_next = ctrl_w;
                                phase_next = PH_CTRL;
                            end
                        end
                    end
                end
                PH_RSTOP:
                begin
                    if (sdone)
                    begin
                        emit = 1'b1; act_next = ACT_START; tx_next = ctrl_r;
                        phase_next = PH_RCTRL;
                    end
                end
                PH_RCTRL:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1;
                        if (bus_error)
                        begin
                            act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = ERR_RCTRL; phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            act_next = ACT_READ; phase_next = PH_RBODY;
                        end
                    end
                end
                PH_RBODY:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1;
                        if (bus_error)
                        begin
                            act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = stat.rem_zero ? ERR_RPRELAST : ERR_RBODY;
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            rv_next = 1'b1; rdat_next = rx_byte;
                            if (!stat.rem_zero)
                            begin
                                cmd.rd_dec = 1'b1; act_next = ACT_READ;
                            end
                            else
                            begin
                                act_next = ACT_LREAD; phase_next = PH_RLAST;
                            end
                        end
                    end
                end
                PH_RLAST:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1;
                        if (bus_error)
                        begin
                            act_next = ACT_STOP; fin_next = 1'b1;
                            err_next = ERR_RLAST2; phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            act_next = ACT_READ; rv_next = 1'b1; rdat_next = rx_byte;
                            phase_next = PH_RFINAL;
                        end
                    end
                end
                PH_RFINAL:
                begin
                    if (bdone)
                    begin
                        emit = 1'b1; act_next = ACT_STOP;
                        if (bus_error)
                        begin
                            fin_next = 1'b1; err_next = ERR_RLAST; phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            phase_next = PH_RSTOPEND;
                        end
                    end
                end
                PH_RSTOPEND:
                begin
                    if (sdone)
                    begin
                        emit = 1'b1; fin_next = 1'b1; ok_next = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DRAIN:
                begin
                    if (sdone)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        ov_next = emit || (ov_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rd_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            calc_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            rd_reg    <= rd_next;
            ov_reg    <= ov_next;
            calc_reg  <= calc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            act_reg  <= act_next;
            tx_reg   <= tx_next;
            rv_reg   <= rv_next;
            rdat_reg <= rdat_next;
            fin_reg  <= fin_next;
            ok_reg   <= ok_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid  = ov_reg;
    assign action     = act_reg;
    assign tx_byte    = tx_reg;
    assign read_valid = rv_reg;
    assign read_data  = rdat_reg;
    assign finished   = fin_reg;
    assign success    = ok_reg;
    assign error_code = err_reg;

endmodule

// ----- hw/rtl/ieas_checker.sv -----
// Port-level checker for the I2C EEPROM access sequencer, bound to the top level.
// Depends on ieas_pkg.
module ieas_checker
    import ieas_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] action,
    input logic       finished,
    input logic       success,
    input logic [3:0] error_code,
    input logic       read_valid
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action))
        else $error("Stalled result beat changed.");

    a_ok_noerr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> finished && error_code == ERR_NONE)
        else $error("Success beat carries an error.");

    a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> action == ACT_STOP && finished && !success)
        else $error("Error beat is not a failing stop.");

    a_rd_act: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> action == ACT_READ || action == ACT_LREAD)
        else $error("Read byte delivered without a read action.");

endmodule

bind i2c_eeprom_access_sequencer ieas_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .finished   (finished),
    .success    (success),
    .error_code (error_code),
    .read_valid (read_valid)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for i2c_eeprom_access_sequencer: directed table, then random
// EEPROM write and read operations, checked beat by beat against an in-bench predictor.
// Depends on ieas_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module testbench;
    import ieas_pkg::*;

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] tx;
        logic       rv;
        logic [7:0] rd;
        logic       fin;
        logic       ok;
        logic [3:0] err;
    } bus_beat_t;

    typedef struct packed {
        logic [2:0]  k;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [7:0]  db;
        logic        ack;
        logic        berr;
        logic [7:0]  rx;
        logic        pinned;
        logic        pin_hit;
        bus_beat_t   pin;
    } stim_row_t;

    localparam bus_beat_t NOB = '{ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE};
    localparam int NROWS = 28;
    localparam stim_row_t DIRECTED [NROWS] = '{
        '{KIND_WRITE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1,
          '{ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE}},
        '{KIND_WRITE, 16'hFFFE, 16'h0002, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1,
          '{ACT_START, 8'hA0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1,
          '{ACT_SEND, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
        '{KIND_BDONE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 8'hFF, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_DATA,  16'h0000, 16'h0000, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_DATA,  16'hFFFF, 16'hFFFF, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_SDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_SDONE, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_SDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1,
          '{ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE}},
        '{3'd7,       16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, NOB},
        '{KIND_READ,  16'h1234, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_SDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1,
          '{ACT_START, 8'hA1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h5A, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'hA5, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1,
          '{ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ERR_RLAST}},
        '{KIND_SDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, NOB},
        '{KIND_WRITE, 16'h0000, 16'h0005, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB},
        '{KIND_BDONE, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1,
          '{ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ERR_CTRL}},
        '{KIND_SDONE, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, NOB}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [15:0] mem_address = '0;
    logic [15:0] byte_count = '0;
    logic [7:0]  data_byte = '0;
    logic        ack_received = 1'b0;
    logic        bus_error = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        finished;
    logic        success;
    logic [3:0]  error_code;

    bus_beat_t   expected_beats [$];
    int          mismatches = 0;
    int          beats_issued = 0;
    bit          in_idle_en = 1'b1;
    bit          out_idle_en = 1'b1;

    phase_t      ph = PH_IDLE;
    logic [15:0] cur_addr = '0;
    logic [15:0] remaining = '0;
    logic [8:0]  chunk_sz = '0;
    logic [8:0]  chunk_rem = '0;
    logic        is_read = 1'b0;
    logic [2:0]  m_devsel = 3'd0;
    logic [7:0]  m_page = 8'd16;
    logic        m_wide = 1'b1;

    i2c_eeprom_access_sequencer dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= out_idle_en && ($urandom_range(99) < 13);
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        bus_beat_t want;
        bus_beat_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{action, tx_byte, read_valid, read_data, finished, success, error_code};
            if (expected_beats.size() == 0)
                flag_mismatch($sformatf("unexpected result beat %p", got));
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf("got %p expected %p", got, want));
            end
        end
    end

    function automatic logic [7:0] control_byte(input logic rd);
        return CTRL_BASE | {4'b0000, m_devsel, rd};
    endfunction

    task automatic predict_sequencer(input logic [2:0] k, input logic [15:0] a16,
                                     input logic [15:0] c16, input logic [7:0] d,
                                     input logic ak, input logic be, input logic [7:0] rxb,
                                     output bit hit, output bus_beat_t b);
        logic [3:0] base;
        logic [3:0] fail_code;
        int ps;
        int chunk;
        bit bdone;
        bit sdone;
        hit = 1'b0;
        b = NOB;
        fail_code = ERR_NONE;
        base = is_read ? ERR_READ_BASE : ERR_NONE;
        bdone = (k == KIND_BDONE);
        sdone = (k == KIND_SDONE);
        case (ph)
            PH_IDLE:
                if (k == KIND_WRITE || k == KIND_READ)
                begin
                    cur_addr = a16;
                    remaining = c16;
                    chunk_sz = '0;
                    chunk_rem = '0;
                    is_read = (k == KIND_READ);
                    hit = 1'b1;
                    if (!is_read && c16 == 0)
                    begin
                        b.fin = 1'b1;
                        b.ok = 1'b1;
                    end
                    else
                    begin
                        ph = PH_CTRL;
                        b.act = ACT_START;
                        b.tx = control_byte(1'b0);
                    end
                end
            PH_CTRL:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be || (!is_read && !ak))
                        fail_code = base + ERR_CTRL;
                    else if (m_wide)
                    begin
                        ph = PH_AHI;
                        b.act = ACT_SEND;
                        b.tx = cur_addr[15:8];
                    end
                    else
                    begin
                        ph = PH_ALO;
                        b.act = ACT_SEND;
                        b.tx = cur_addr[7:0];
                    end
                end
            PH_AHI:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be)
                        fail_code = base + ERR_AHI;
                    else
                    begin
                        ph = PH_ALO;
                        b.act = ACT_SEND;
                        b.tx = cur_addr[7:0];
                    end
                end
            PH_ALO:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be)
                        fail_code = base + ERR_ALO;
                    else if (is_read)
                    begin
                        ph = PH_RSTOP;
                        b.act = ACT_STOP;
                    end
                    else
                    begin
                        ps = (m_page == 0) ? 256 : int'(m_page);
                        chunk = ps - (int'(cur_addr) % ps);
                        if (int'(remaining) < chunk)
                            chunk = int'(remaining);
                        chunk_sz = 9'(chunk);
                        chunk_rem = 9'(chunk);
                        ph = PH_WWAIT;
                        b.act = ACT_REQ;
                    end
                end
            PH_WWAIT:
                if (k == KIND_DATA)
                begin
                    hit = 1'b1;
                    ph = PH_WSENT;
                    b.act = ACT_SEND;
                    b.tx = d;
                end
            PH_WSENT:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be || !ak)
                        fail_code = ERR_WDATA;
                    else
                    begin
                        if (chunk_rem > 0)
                            chunk_rem--;
                        if (chunk_rem > 0)
                        begin
                            ph = PH_WWAIT;
                            b.act = ACT_REQ;
                        end
                        else
                        begin
                            ph = PH_WSTOP;
                            b.act = ACT_STOP;
                        end
                    end
                end
            PH_WSTOP:
                if (sdone)
                begin
                    hit = 1'b1;
                    ph = PH_PBYTE;
                    b.act = ACT_START;
                    b.tx = control_byte(1'b0);
                end
            PH_PBYTE:
                if (bdone)
                begin
                    hit = 1'b1;
                    ph = PH_PSTOP;
                    b.act = ACT_STOP;
                end
            PH_PSTOP:
                if (sdone)
                begin
                    hit = 1'b1;
                    if (!ak)
                    begin
                        ph = PH_PBYTE;
                        b.act = ACT_START;
                        b.tx = control_byte(1'b0);
                    end
                    else
                    begin
                        remaining = remaining - chunk_sz;
                        cur_addr = cur_addr + chunk_sz;
                        if (remaining == 0)
                        begin
                            ph = PH_IDLE;
                            b.fin = 1'b1;
                            b.ok = 1'b1;
                        end
                        else
                        begin
                            ph = PH_CTRL;
                            b.act = ACT_START;
                            b.tx = control_byte(1'b0);
                        end
                    end
                end
            PH_RSTOP:
                if (sdone)
                begin
                    hit = 1'b1;
                    ph = PH_RCTRL;
                    b.act = ACT_START;
                    b.tx = control_byte(1'b1);
                end
            PH_RCTRL:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be)
                        fail_code = ERR_RCTRL;
                    else
                    begin
                        ph = PH_RBODY;
                        b.act = ACT_READ;
                    end
                end
            PH_RBODY:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (remaining > 0)
                    begin
                        if (be)
                            fail_code = ERR_RBODY;
                        else
                        begin
                            remaining--;
                            b.act = ACT_READ;
                            b.rv = 1'b1;
                            b.rd = rxb;
                        end
                    end
                    else if (be)
                        fail_code = ERR_RPRELAST;
                    else
                    begin
                        ph = PH_RLAST;
                        b.act = ACT_LREAD;
                        b.rv = 1'b1;
                        b.rd = rxb;
                    end
                end
            PH_RLAST:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be)
                        fail_code = ERR_RLAST2;
                    else
                    begin
                        ph = PH_RFINAL;
                        b.act = ACT_READ;
                        b.rv = 1'b1;
                        b.rd = rxb;
                    end
                end
            PH_RFINAL:
                if (bdone)
                begin
                    hit = 1'b1;
                    if (be)
                        fail_code = ERR_RLAST;
                    else
                    begin
                        ph = PH_RSTOPEND;
                        b.act = ACT_STOP;
                    end
                end
            PH_RSTOPEND:
                if (sdone)
                begin
                    hit = 1'b1;
                    ph = PH_IDLE;
                    b.fin = 1'b1;
                    b.ok = 1'b1;
                end
            PH_DRAIN:
                if (sdone)
                    ph = PH_IDLE;
            default:
                ph = PH_IDLE;
        endcase
        if (fail_code != ERR_NONE)
        begin
            ph = PH_DRAIN;
            b = NOB;
            b.act = ACT_STOP;
            b.fin = 1'b1;
            b.err = fail_code;
        end
    endtask

    task automatic issue_beat(input stim_row_t row);
        bit hit;
        bus_beat_t b;
        predict_sequencer(row.k, row.addr, row.cnt, row.db, row.ack, row.berr, row.rx,
                          hit, b);
        if (row.pinned)
        begin
            hit = row.pin_hit;
            b = row.pin;
        end
        if (hit)
        begin
            expected_beats.push_back(b);
            beats_issued++;
        end
        in_valid <= 1'b1;
        kind <= row.k;
        mem_address <= row.addr;
        byte_count <= row.cnt;
        data_byte <= row.db;
        ack_received <= row.ack;
        bus_error <= row.berr;
        rx_byte <= row.rx;
        do
            @(posedge clk);
        while (in_stall);
        if (in_idle_en && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic random_beat(input logic [2:0] k, input logic [15:0] a16,
                               input logic [15:0] c16, input logic ak, input logic be);
        stim_row_t row;
        row = '{k, a16, c16, 8'($urandom), ak, be, 8'($urandom), 1'b0, 1'b0, NOB};
        issue_beat(row);
    endtask

    task automatic run_operation();
        logic [2:0] k;
        logic ak;
        logic be;
        int ps;
        int r;
        logic [15:0] a16;
        logic [15:0] c16;
        ps = (m_page == 0) ? 256 : int'(m_page);
        r = $urandom_range(99);
        if ($urandom_range(1) == 0)
        begin
            a16 = (ps >= 64) ? 16'($urandom) : 16'($urandom_range(0, ps * 64));
            c16 = (r < 5) ? 16'd0 : (r < 10) ? 16'($urandom_range(41, 300))
                                            : 16'($urandom_range(1, 40));
            random_beat(KIND_WRITE, a16, c16, 1'b1, 1'b0);
        end
        else
        begin
            c16 = (r < 3) ? 16'($urandom_range(21, 200)) : 16'($urandom_range(0, 20));
            random_beat(KIND_READ, 16'($urandom), c16, 1'b1, 1'b0);
        end
        while (ph != PH_IDLE)
        begin
            ak = ($urandom_range(99) >= 3);
            be = ($urandom_range(99) < 2);
            case (ph)
                PH_WWAIT: k = KIND_DATA;
                PH_WSTOP, PH_RSTOP, PH_RSTOPEND, PH_DRAIN: k = KIND_SDONE;
                PH_PSTOP:
                begin
                    k = KIND_SDONE;
                    ak = ($urandom_range(99) < 70);
                end
                default: k = KIND_BDONE;
            endcase
            if ($urandom_range(99) < 4)
                k = 3'($urandom_range(7));
            random_beat(k, 16'($urandom), 16'($urandom), ak, be);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] devsel, input logic [7:0] page,
                              input logic wide);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DEVSEL;
        cfg_data <= {5'($urandom), devsel};
        @(posedge clk);
        cfg_index <= CFG_PAGE;
        cfg_data <= page;
        @(posedge clk);
        cfg_index <= CFG_WIDE;
        cfg_data <= {7'($urandom), wide};
        @(posedge clk);
        cfg_write <= 1'b0;
        m_devsel = devsel;
        m_page = page;
        m_wide = wide;
    endtask

    initial
    begin
        #50_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        logic [2:0] fixed_devsel [5];
        logic [7:0] fixed_page [5];
        logic       fixed_wide [5];
        logic [7:0] page;
        int r;
        fixed_devsel = '{3'd0, 3'd7, 3'd5, 3'd3, 3'd7};
        fixed_page = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd2};
        fixed_wide = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NROWS; i++)
            issue_beat(DIRECTED[i]);
        for (int p = 0; p < 16; p++)
        begin
            wait_drained();
            if (p > 0 && p < 5)
                set_config(fixed_devsel[p], fixed_page[p], fixed_wide[p]);
            else if (p >= 5)
            begin
                r = $urandom_range(99);
                page = (r < 5) ? 8'd1 : (r < 10) ? 8'd255 : (r < 15) ? 8'd0
                                                           : 8'($urandom_range(1, 255));
                set_config(3'($urandom), page, 1'($urandom));
            end
            in_idle_en = (p != 3);
            out_idle_en = (p != 3);
            while (beats_issued < (p + 1) * 100 + NROWS)
                run_operation();
        end
        wait_drained();
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
